// ----- hw/rtl/vrra_pkg.sv -----
package vrra_pkg;

  // Field widths of the request and result items
  localparam int ADDR_BITS = 20;
  localparam int SIZE_W    = 21;
  localparam int AGE_W     = 6;
  localparam int COUNT_W   = 7;
  localparam int STATUS_W  = 2;

  localparam int MAX_RECORDS_DEF = 64;

  // Region size after reset and the largest usable region
  localparam logic [SIZE_W-1:0] REGION_RESET = SIZE_W'(64'd1 << ADDR_BITS);
  localparam logic [SIZE_W-1:0] REGION_CAP   = SIZE_W'(64'd1 << ADDR_BITS);

  // Request commands
  localparam logic CMD_APPEND  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERSIZE  = 2'd2;

  // Descriptor read address selection
  localparam logic [1:0] RD_OLDEST  = 2'd0;
  localparam logic [1:0] RD_NEWEST  = 2'd1;
  localparam logic [1:0] RD_EXTRACT = 2'd2;

  // Result register source selection
  localparam logic [1:0] RES_WRITE = 2'd0;
  localparam logic [1:0] RES_EXT   = 2'd1;
  localparam logic [1:0] RES_MISS  = 2'd2;
  localparam logic [1:0] RES_OVER  = 2'd3;

  typedef struct packed {
    logic              cmd;
    logic [SIZE_W-1:0] record_bytes;
    logic [AGE_W-1:0]  age_from_newest;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [ADDR_BITS-1:0] record_address;
    logic [SIZE_W-1:0]    record_size;
    logic [COUNT_W-1:0]   records_held;
    logic [COUNT_W-1:0]   records_evicted;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [SIZE_W-1:0]    size;
  } desc_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       evict;
    logic       latch_new;
    logic       place_zero;
    logic       place_nend;
    logic       wr_en;
    logic       res_load;
    logic [1:0] rd_sel;
    logic [1:0] res_sel;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_ext;
    logic age_miss;
    logic bad_size;
    logic full;
    logic empty;
    logic wrapped;
    logic gap_ok;
    logic fits_end;
    logic old_lt_need;
  } ctrl_stat_t;

endpackage

// ----- hw/rtl/vrra_ctrl.sv -----
module vrra_ctrl
  import vrra_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  ctrl_stat_t st,
  output ctrl_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_PREP   = 4'd2;
  localparam logic [3:0] S_NEWEST = 4'd3;
  localparam logic [3:0] S_RD_OLD = 4'd4;
  localparam logic [3:0] S_CHK    = 4'd5;
  localparam logic [3:0] S_WRITE  = 4'd6;
  localparam logic [3:0] S_EXT    = 4'd7;
  localparam logic [3:0] S_REJ    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       loop_b;
  logic       loop_b_next;
  logic       ov;
  logic       out_free;

  assign out_free  = !ov || out_ready;
  assign in_ready  = (state == S_IDLE);
  assign out_valid = ov;

  // Sequence one request through decode, eviction walk and result
  always_comb begin
    state_next  = state;
    loop_b_next = loop_b;
    cmd         = '0;
    cmd.rd_sel  = RD_OLDEST;
    cmd.res_sel = RES_WRITE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          loop_b_next = 1'b0;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.is_ext) begin
          if (st.age_miss) begin
            state_next = S_REJ;
          end else begin
            cmd.rd_sel = RD_EXTRACT;
            state_next = S_EXT;
          end
        end else if (st.bad_size) begin
          state_next = S_REJ;
        end else begin
          cmd.evict  = st.full;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        if (st.empty) begin
          cmd.place_zero = 1'b1;
          state_next     = S_WRITE;
        end else begin
          cmd.rd_sel = RD_NEWEST;
          state_next = S_NEWEST;
        end
      end
      S_NEWEST: begin
        cmd.latch_new = 1'b1;
        state_next    = S_RD_OLD;
      end
      S_RD_OLD: begin
        if (st.empty) begin
          cmd.place_zero = 1'b1;
          state_next     = S_WRITE;
        end else begin
          cmd.rd_sel = RD_OLDEST;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (!loop_b && st.wrapped) begin
          // Wrapped: the gap runs from the newest end to the oldest start
          if (st.gap_ok) begin
            cmd.place_nend = 1'b1;
            state_next     = S_WRITE;
          end else begin
            cmd.evict  = 1'b1;
            state_next = S_RD_OLD;
          end
        end else if (!loop_b && st.fits_end) begin
          cmd.place_nend = 1'b1;
          state_next     = S_WRITE;
        end else begin
          // Restart at offset zero: drop oldest records below the new end
          loop_b_next = 1'b1;
          if (st.old_lt_need) begin
            cmd.evict  = 1'b1;
            state_next = S_RD_OLD;
          end else begin
            cmd.place_zero = 1'b1;
            state_next     = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        if (out_free) begin
          cmd.wr_en    = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_WRITE;
          state_next   = S_IDLE;
        end
      end
      S_EXT: begin
        cmd.rd_sel = RD_EXTRACT;
        if (out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_EXT;
          state_next   = S_IDLE;
        end
      end
      S_REJ: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = st.is_ext ? RES_MISS : RES_OVER;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state and the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      loop_b <= 1'b0;
      ov     <= 1'b0;
    end else begin
      state  <= state_next;
      loop_b <= loop_b_next;
      if (cmd.res_load) begin
        ov <= 1'b1;
      end else if (out_ready) begin
        ov <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/vrra_dpath.sv -----
module vrra_dpath
  import vrra_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  in_item_t          in_data,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_data,
  input  ctrl_cmd_t         cmd,
  output ctrl_stat_t        st,
  output out_item_t         out_data
);

  localparam int SLOT_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
  localparam int CMP_W  = (CNT_W > AGE_W) ? CNT_W : AGE_W;
  localparam logic [SLOT_W:0]  MAX_S   = (SLOT_W + 1)'(MAX_RECORDS);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RECORDS);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  logic [SIZE_W-1:0]    region;
  logic [SIZE_W-1:0]    eff;
  logic                 is_ext;
  logic [SIZE_W-1:0]    need;
  logic [AGE_W-1:0]     age;
  logic [SIZE_W-1:0]    eff_r;
  logic [SLOT_W-1:0]    oldest_slot;
  logic [CNT_W-1:0]     held;
  logic [CNT_W-1:0]     held_inc;
  logic [CNT_W-1:0]     evicted;
  logic [ADDR_BITS-1:0] nw_addr;
  logic [SIZE_W-1:0]    nend;
  logic [ADDR_BITS-1:0] place;
  logic [SLOT_W-1:0]    rd_slot;
  logic [SLOT_W-1:0]    wr_slot;
  logic [CNT_W-1:0]     ext_ofs;
  logic [SIZE_W-1:0]    old21;
  desc_t                rd_data;
  desc_t                mem [MAX_RECORDS];

  // Ring index a given offset past a base slot
  function automatic logic [SLOT_W-1:0] slot_at(input logic [SLOT_W-1:0] base,
                                                input logic [SLOT_W-1:0] ofs);
    logic [SLOT_W:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= MAX_S) begin
      sum = sum - MAX_S;
    end
    return sum[SLOT_W-1:0];
  endfunction

  // Clamp the configured region to the usable range
  always_comb begin
    if (region == '0) begin
      eff = SIZE_W'(1);
    end else if (region > REGION_CAP) begin
      eff = REGION_CAP;
    end else begin
      eff = region;
    end
  end

  assign held_inc = held + ONE_CNT;
  assign ext_ofs  = held - ONE_CNT - CNT_W'(age);
  assign old21    = {1'b0, rd_data.addr};
  assign wr_slot  = (held == '0) ? '0 : slot_at(oldest_slot, held[SLOT_W-1:0]);

  // Select the descriptor read address
  always_comb begin
    case (cmd.rd_sel)
      RD_NEWEST:  rd_slot = slot_at(oldest_slot, SLOT_W'(held - ONE_CNT));
      RD_EXTRACT: rd_slot = slot_at(oldest_slot, ext_ofs[SLOT_W-1:0]);
      default:    rd_slot = oldest_slot;
    endcase
  end

  // Descriptor memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_slot] <= '{addr: place, size: need};
    end
    rd_data <= mem[rd_slot];
  end

  // Report conditions to the controller
  always_comb begin
    st.is_ext      = is_ext;
    st.age_miss    = CMP_W'(age) >= CMP_W'(held);
    st.bad_size    = (need == '0) || (need > eff_r);
    st.full        = (held >= MAX_CNT);
    st.empty       = (held == '0);
    st.wrapped     = rd_data.addr > nw_addr;
    st.gap_ok      = (old21 >= nend) && ((old21 - nend) >= need);
    st.fits_end    = (nend <= eff_r) && (need <= (eff_r - nend));
    st.old_lt_need = old21 < need;
  end

  // Hold the region register
  always_ff @(posedge clk) begin
    if (rst) begin
      region <= REGION_RESET;
    end else if (cfg_we) begin
      region <= cfg_data;
    end
  end

  // Ring bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_slot <= '0;
      held        <= '0;
    end else if (cmd.evict) begin
      oldest_slot <= slot_at(oldest_slot, SLOT_W'(1));
      held        <= held - ONE_CNT;
    end else if (cmd.wr_en) begin
      if (held == '0) begin
        oldest_slot <= '0;
      end
      held <= held_inc;
    end
  end

  // Capture the request and the working values of the placement search
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_ext  <= (in_data.cmd == CMD_EXTRACT);
      need    <= in_data.record_bytes;
      age     <= in_data.age_from_newest;
      eff_r   <= eff;
      evicted <= '0;
    end else if (cmd.evict) begin
      evicted <= evicted + ONE_CNT;
    end
    if (cmd.latch_new) begin
      nw_addr <= rd_data.addr;
      nend    <= old21 + rd_data.size;
    end
    if (cmd.place_zero) begin
      place <= '0;
    end else if (cmd.place_nend) begin
      place <= nend[ADDR_BITS-1:0];
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_WRITE: begin
          out_data.status          <= STATUS_OK;
          out_data.record_address  <= place;
          out_data.record_size     <= need;
          out_data.records_held    <= COUNT_W'(held_inc);
          out_data.records_evicted <= COUNT_W'(evicted);
        end
        RES_EXT: begin
          out_data.status          <= STATUS_OK;
          out_data.record_address  <= rd_data.addr;
          out_data.record_size     <= rd_data.size;
          out_data.records_held    <= COUNT_W'(held);
          out_data.records_evicted <= '0;
        end
        RES_MISS: begin
          out_data.status          <= STATUS_NOT_FOUND;
          out_data.record_address  <= '0;
          out_data.record_size     <= '0;
          out_data.records_held    <= COUNT_W'(held);
          out_data.records_evicted <= '0;
        end
        default: begin
          out_data.status          <= STATUS_OVERSIZE;
          out_data.record_address  <= '0;
          out_data.record_size     <= '0;
          out_data.records_held    <= COUNT_W'(held);
          out_data.records_evicted <= '0;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/variable_record_ring_allocator_top.sv -----
// Channel   Signals                         Moves
// in        in_valid  in_ready  in_data     append or extract request
// out       out_valid out_ready out_data    one result per request
// cfg       cfg_valid cfg_ready cfg_data    region size in bytes
//
// One request at a time. Rejected appends, missing records and extracts pass
// from decode to a result state, an append to an empty store places its record
// at offset zero, and any other append reads the newest and then the oldest
// descriptor, evicting records during the search (the eviction forced by a full
// table is done in decode): each descriptor examined costs a read of the single
// registered memory port. A waiting result does not block the next request
// until that request's own result is ready. Reset is synchronous; the
// descriptor memory is not cleared and only written entries are ever read.
module variable_record_ring_allocator_top
  import vrra_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t st;

  assign cfg_ready = 1'b1;

  vrra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  vrra_dpath #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .st       (st),
    .out_data (out_data)
  );

  // Never evict from an empty store
  a_evict_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.evict |-> !st.empty)
    else $error("eviction with no records held");

  // Never write a descriptor into a full table
  a_write_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> !st.full)
    else $error("descriptor write into full table");

  // Never overwrite a result that has not been taken
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // Take no new request right after one is accepted
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

endmodule
